@@ rtl/are_pkg.sv @@
// Package for the ARP resolution engine: command and result codes, widths,
// register indexes and default parameter values. No dependencies.
package are_pkg;

  localparam int CacheEntriesDef   = 16;
  localparam int PendingEntriesDef = 8;
  localparam int QueueDepthDef     = 16;

  localparam int MacW = 48;
  localparam int IpW  = 32;
  localparam int TagW = 16;
  localparam int AgeW = 16;

  localparam logic [AgeW-1:0] TtlReset  = 16'd30000;
  localparam logic [AgeW-1:0] HoldReset = 16'd5000;
  localparam logic [MacW-1:0] BcastMac  = '1;

  typedef enum logic [1:0] {
    CMD_SEND = 2'd0,
    CMD_RECV = 2'd1,
    CMD_TICK = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_IPV4  = 2'd0,
    KIND_REQ   = 2'd1,
    KIND_REPLY = 2'd2,
    KIND_DROP  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REG_OWN_MAC = 2'd0,
    REG_OWN_IP  = 2'd1,
    REG_TTL     = 2'd2,
    REG_HOLD    = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]      cmd;
    logic [IpW-1:0]  ip_addr;
    logic [MacW-1:0] mac_addr;
    logic [MacW-1:0] dst_mac;
    logic [IpW-1:0]  target_ip;
    logic            is_request;
    logic            parse_ok;
    logic [TagW-1:0] dgram_tag;
    logic [AgeW-1:0] elapsed_ms;
  } in_item_t;

  typedef struct packed {
    kind_t           kind;
    logic [MacW-1:0] dest_mac;
    logic [IpW-1:0]  arp_target_ip;
    logic [TagW-1:0] out_tag;
    logic            last;
  } out_item_t;

  // Saturating age update, shared by both tables.
  function automatic logic [AgeW-1:0] age_add(input logic [AgeW-1:0] a,
                                              input logic [AgeW-1:0] d);
    logic [AgeW:0] s;
    s = {1'b0, a} + {1'b0, d};
    age_add = s[AgeW] ? '1 : s[AgeW-1:0];
  endfunction

endpackage

@@ rtl/are_out_buf.sv @@
// Two-entry result buffer between the sequencer and the output stream.
// Depends on are_pkg.
module are_out_buf (
  input  logic               clk,
  input  logic               rst,
  input  are_pkg::out_item_t push_item,
  input  logic               push,
  output logic               space,
  output are_pkg::out_item_t head,
  output logic               head_valid,
  input  logic               pop
);
  import are_pkg::*;

  out_item_t  slot [2];
  logic [1:0] count;
  logic       rd;
  logic       wr;
  logic       empty;

  assign space      = (count != 2'd2);
  assign empty      = (count == 2'd0);
  assign head_valid = !empty;
  assign head       = slot[rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      rd    <= 1'b0;
      wr    <= 1'b0;
    end else begin
      if (push) begin
        slot[wr] <= push_item;
        wr       <= !wr;
      end
      if (pop) rd <= !rd;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

@@ rtl/are_seq.sv @@
// Sequencer: walks cache, pending table and queue one entry per cycle save
// buffer stalls; single shared compare and age unit. Depends on are_pkg.
module are_seq #(
  parameter int CACHE_ENTRIES   = are_pkg::CacheEntriesDef,
  parameter int PENDING_ENTRIES = are_pkg::PendingEntriesDef,
  parameter int QUEUE_DEPTH     = are_pkg::QueueDepthDef
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  are_pkg::in_item_t           item,
  output logic                        busy,
  input  logic [are_pkg::MacW-1:0]    own_mac,
  input  logic [are_pkg::IpW-1:0]     own_ip,
  input  logic [are_pkg::AgeW-1:0]    cache_ttl_ms,
  input  logic [are_pkg::AgeW-1:0]    request_hold_ms,
  output are_pkg::out_item_t          res,
  output logic                        res_push,
  input  logic                        res_space
);
  import are_pkg::*;

  localparam int CW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int PW = (PENDING_ENTRIES > 1) ? $clog2(PENDING_ENTRIES) : 1;
  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NW = ((CW > PW) ? ((CW > QW) ? CW : QW) : ((PW > QW) ? PW : QW)) + 1;

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_CSCAN  = 12'b000000000010,
    S_PSCAN  = 12'b000000000100,
    S_REQ    = 12'b000000001000,
    S_ENQ    = 12'b000000010000,
    S_LSCAN  = 12'b000000100000,
    S_LWRITE = 12'b000001000000,
    S_QREL   = 12'b000010000000,
    S_QFLUSH = 12'b000100000000,
    S_REPLY  = 12'b001000000000,
    S_PTICK  = 12'b010000000000,
    S_CTICK  = 12'b100000000000
  } state_t;

  state_t state, state_next;

  logic            c_valid [CACHE_ENTRIES];
  logic [IpW-1:0]  c_ip    [CACHE_ENTRIES];
  logic [MacW-1:0] c_mac   [CACHE_ENTRIES];
  logic [AgeW-1:0] c_age   [CACHE_ENTRIES];
  logic            p_valid [PENDING_ENTRIES];
  logic [IpW-1:0]  p_ip    [PENDING_ENTRIES];
  logic [AgeW-1:0] p_age   [PENDING_ENTRIES];
  logic            q_valid [QUEUE_DEPTH];
  logic [IpW-1:0]  q_ip    [QUEUE_DEPTH];
  logic [TagW-1:0] q_tag   [QUEUE_DEPTH];

  in_item_t        cur;
  logic [NW-1:0]   idx;
  logic [QW:0]     wptr;     // queue compaction write pointer
  logic [QW:0]     qcount;   // number of valid queue entries (prefix)
  logic            held;
  logic            free_found;
  logic [PW-1:0]   free_slot;
  logic            hit_found;
  logic [CW-1:0]   hit_slot;
  logic            empty_found;
  logic [CW-1:0]   empty_slot;
  logic [CW-1:0]   oldest;
  logic            rel_pend; // the queue entry at idx is released
  logic            q_stall;  // a released tag waits for buffer space
  // A released tag is held back until the next one is found, so that the
  // final release of the scan can carry the last flag.
  logic            hb_valid;
  logic [TagW-1:0] hb_tag;

  // Shared unit: one address compare and one saturating age add.
  logic [IpW-1:0]  cmp_a;
  logic            cmp_eq;
  logic [AgeW-1:0] age_in;
  logic [AgeW-1:0] age_out;
  logic [CW-1:0]   ci;
  logic [PW-1:0]   pi;
  logic [QW-1:0]   qi;

  assign ci = idx[CW-1:0];
  assign pi = idx[PW-1:0];
  assign qi = idx[QW-1:0];

  always_comb begin
    cmp_a  = c_ip[ci];
    age_in = c_age[ci];
    if (state == S_PSCAN || state == S_PTICK) begin
      cmp_a  = p_ip[pi];
      age_in = p_age[pi];
    end else if (state == S_QREL) begin
      cmp_a  = q_ip[qi];
    end
  end
  assign cmp_eq  = (cmp_a == cur.ip_addr);
  assign age_out = age_add(age_in, cur.elapsed_ms);

  logic frame_ok;
  assign frame_ok = ((cur.dst_mac == own_mac) || (cur.dst_mac == BcastMac)) && cur.parse_ok;
  logic reply_due;
  assign reply_due = cur.is_request && (cur.target_ip == own_ip);

  // The drop follows the request in the same item, so the request is only
  // last when the queue still has room.
  logic q_full;
  assign q_full = (qcount == (QW+1)'(QUEUE_DEPTH));

  assign rel_pend = (state == S_QREL) && cmp_eq;
  assign q_stall  = rel_pend && hb_valid && !res_space;

  assign busy = (state != S_IDLE);

  // Result formation.
  always_comb begin
    res      = '0;
    res_push = 1'b0;
    unique case (state)
      S_CSCAN: begin
        if (c_valid[ci] && cmp_eq && res_space) begin
          res.kind     = KIND_IPV4;
          res.dest_mac = c_mac[ci];
          res.out_tag  = cur.dgram_tag;
          res.last     = 1'b1;
          res_push     = 1'b1;
        end
      end
      S_REQ: begin
        res.kind          = KIND_REQ;
        res.dest_mac      = BcastMac;
        res.arp_target_ip = cur.ip_addr;
        res.last          = !q_full;
        res_push          = res_space;
      end
      S_ENQ: begin
        if (q_full) begin
          res.kind    = KIND_DROP;
          res.out_tag = cur.dgram_tag;
          res.last    = 1'b1;
          res_push    = res_space;
        end
      end
      S_QREL: begin
        if (rel_pend && hb_valid) begin
          res.kind     = KIND_IPV4;
          res.dest_mac = cur.mac_addr;
          res.out_tag  = hb_tag;
          res.last     = 1'b0;
          res_push     = res_space;
        end
      end
      S_QFLUSH: begin
        res.kind     = KIND_IPV4;
        res.dest_mac = cur.mac_addr;
        res.out_tag  = hb_tag;
        res.last     = !reply_due;
        res_push     = res_space;
      end
      S_REPLY: begin
        res.kind          = KIND_REPLY;
        res.dest_mac      = cur.mac_addr;
        res.arp_target_ip = cur.ip_addr;
        res.last          = 1'b1;
        res_push          = res_space;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (cmd_t'(item.cmd))
            CMD_SEND: state_next = S_CSCAN;
            CMD_RECV: state_next = S_LSCAN;
            CMD_TICK: state_next = S_PTICK;
            default:  state_next = S_IDLE;
          endcase
        end
      end
      S_CSCAN: begin
        if (c_valid[ci] && cmp_eq) begin
          if (res_space) state_next = S_IDLE;
        end else if (idx == NW'(CACHE_ENTRIES - 1)) begin
          state_next = S_PSCAN;
        end
      end
      S_PSCAN: begin
        if (idx == NW'(PENDING_ENTRIES - 1))
          state_next = (held || (p_valid[pi] && cmp_eq)) ? S_ENQ : S_REQ;
      end
      S_REQ:    if (res_space) state_next = S_ENQ;
      S_ENQ:    if (!q_full || res_space) state_next = S_IDLE;
      S_LSCAN: begin
        if (!frame_ok) state_next = S_IDLE;
        else if (idx == NW'(CACHE_ENTRIES - 1)) state_next = S_LWRITE;
      end
      S_LWRITE: state_next = (qcount == '0) ? (reply_due ? S_REPLY : S_IDLE) : S_QREL;
      S_QREL: begin
        if (!q_stall && idx == NW'(qcount) - 1'b1)
          state_next = (hb_valid || rel_pend) ? S_QFLUSH : (reply_due ? S_REPLY : S_IDLE);
      end
      S_QFLUSH: if (res_space) state_next = reply_due ? S_REPLY : S_IDLE;
      S_REPLY:  if (res_space) state_next = S_IDLE;
      S_PTICK:  if (idx == NW'(PENDING_ENTRIES - 1)) state_next = S_CTICK;
      S_CTICK:  if (idx == NW'(CACHE_ENTRIES - 1)) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      for (int i = 0; i < CACHE_ENTRIES; i++) c_valid[i] <= 1'b0;
      for (int i = 0; i < PENDING_ENTRIES; i++) p_valid[i] <= 1'b0;
      for (int i = 0; i < QUEUE_DEPTH; i++) q_valid[i] <= 1'b0;
      qcount   <= '0;
      idx      <= '0;
      hb_valid <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: begin
          cur         <= item;
          idx         <= '0;
          held        <= 1'b0;
          free_found  <= 1'b0;
          free_slot   <= '0;
          hit_found   <= 1'b0;
          hit_slot    <= '0;
          empty_found <= 1'b0;
          empty_slot  <= '0;
          oldest      <= '0;
          wptr        <= '0;
          hb_valid    <= 1'b0;
          hb_tag      <= '0;
        end
        S_CSCAN: begin
          if (!(c_valid[ci] && cmp_eq) && idx == NW'(CACHE_ENTRIES - 1)) idx <= '0;
          else if (!(c_valid[ci] && cmp_eq)) idx <= idx + 1'b1;
        end
        S_PSCAN: begin
          if (p_valid[pi]) begin
            if (cmp_eq) held <= 1'b1;
          end else if (!free_found) begin
            free_found <= 1'b1;
            free_slot  <= pi;
          end
          if (idx == NW'(PENDING_ENTRIES - 1)) begin
            idx <= '0;
            if (!(held || (p_valid[pi] && cmp_eq))) begin
              if (free_found) begin
                p_valid[free_slot] <= 1'b1;
                p_ip[free_slot]    <= cur.ip_addr;
                p_age[free_slot]   <= '0;
              end else if (!p_valid[pi]) begin
                p_valid[pi] <= 1'b1;
                p_ip[pi]    <= cur.ip_addr;
                p_age[pi]   <= '0;
              end
            end
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_REQ: ;
        S_ENQ: begin
          if (!q_full) begin
            q_valid[qcount[QW-1:0]] <= 1'b1;
            q_ip[qcount[QW-1:0]]    <= cur.ip_addr;
            q_tag[qcount[QW-1:0]]   <= cur.dgram_tag;
            qcount                  <= qcount + 1'b1;
          end
        end
        S_LSCAN: begin
          if (c_valid[ci] && cmp_eq && !hit_found) begin
            hit_found <= 1'b1;
            hit_slot  <= ci;
          end
          if (!c_valid[ci] && !empty_found) begin
            empty_found <= 1'b1;
            empty_slot  <= ci;
          end
          if (c_age[ci] > c_age[oldest]) oldest <= ci;
          idx <= idx + 1'b1;
        end
        S_LWRITE: begin
          idx <= '0;
          if (hit_found) begin
            c_valid[hit_slot] <= 1'b1;
            c_mac[hit_slot]   <= cur.mac_addr;
            c_age[hit_slot]   <= '0;
          end else if (empty_found) begin
            c_valid[empty_slot] <= 1'b1;
            c_ip[empty_slot]    <= cur.ip_addr;
            c_mac[empty_slot]   <= cur.mac_addr;
            c_age[empty_slot]   <= '0;
          end else begin
            c_ip[oldest]  <= cur.ip_addr;
            c_mac[oldest] <= cur.mac_addr;
            c_age[oldest] <= '0;
          end
        end
        S_QREL: begin
          if (!q_stall) begin
            if (rel_pend) begin
              hb_valid <= 1'b1;
              hb_tag   <= q_tag[qi];
            end else begin
              q_ip[wptr[QW-1:0]]  <= q_ip[qi];
              q_tag[wptr[QW-1:0]] <= q_tag[qi];
              wptr                <= wptr + 1'b1;
            end
            if (idx == NW'(qcount) - 1'b1) begin
              for (int i = 0; i < QUEUE_DEPTH; i++)
                q_valid[i] <= ((QW+1)'(i) < (wptr + {{QW{1'b0}}, !rel_pend}));
              qcount <= wptr + {{QW{1'b0}}, !rel_pend};
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        S_QFLUSH: ;
        S_REPLY: ;
        S_PTICK: begin
          if (p_valid[pi]) begin
            p_age[pi] <= age_out;
            if (age_out >= request_hold_ms) p_valid[pi] <= 1'b0;
          end
          idx <= (idx == NW'(PENDING_ENTRIES - 1)) ? '0 : idx + 1'b1;
        end
        S_CTICK: begin
          if (c_valid[ci]) begin
            c_age[ci] <= age_out;
            if (age_out >= cache_ttl_ms) c_valid[ci] <= 1'b0;
          end
          idx <= idx + 1'b1;
        end
        default: ;
      endcase
    end
  end
endmodule

@@ rtl/arp_resolution_engine_top.sv @@
// ARP resolution engine. One item is handled at a time by a sequencer that
// visits one table entry per cycle unless the output buffer is full: a send
// walks the cache and, on a miss, the pending table, a received frame the
// cache and then the queue, a tick the pending table and then the cache, all
// through the single shared compare and age unit. Results leave through a
// two-entry buffer, so a stalled output holds the sequencer only when full.
// Depends on are_pkg, are_seq and are_out_buf.
module arp_resolution_engine_top #(
  parameter int CACHE_ENTRIES   = are_pkg::CacheEntriesDef,
  parameter int PENDING_ENTRIES = are_pkg::PendingEntriesDef,
  parameter int QUEUE_DEPTH     = are_pkg::QueueDepthDef
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // cmd
  input  logic [1:0]   s_axis_tuser,
  // ip_addr, mac_addr, dst_mac, target_ip, is_request, parse_ok,
  // dgram_tag, elapsed_ms; 194 bits used, 6 zero pad bits
  input  logic [199:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // kind
  output logic [1:0]   m_axis_tuser,
  // dest_mac, arp_target_ip, out_tag
  output logic [95:0]  m_axis_tdata,
  output logic         m_axis_tlast,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [47:0]  cfg_data
);
  import are_pkg::*;

  logic [MacW-1:0] own_mac;
  logic [IpW-1:0]  own_ip;
  logic [AgeW-1:0] cache_ttl_ms;
  logic [AgeW-1:0] request_hold_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_mac         <= '0;
      own_ip          <= '0;
      cache_ttl_ms    <= TtlReset;
      request_hold_ms <= HoldReset;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_OWN_MAC: own_mac         <= cfg_data;
        REG_OWN_IP:  own_ip          <= cfg_data[IpW-1:0];
        REG_TTL:     cache_ttl_ms    <= cfg_data[AgeW-1:0];
        REG_HOLD:    request_hold_ms <= cfg_data[AgeW-1:0];
      endcase
    end
  end

  in_item_t item;
  assign item.cmd        = s_axis_tuser;
  assign item.ip_addr    = s_axis_tdata[31:0];
  assign item.mac_addr   = s_axis_tdata[79:32];
  assign item.dst_mac    = s_axis_tdata[127:80];
  assign item.target_ip  = s_axis_tdata[159:128];
  assign item.is_request = s_axis_tdata[160];
  assign item.parse_ok   = s_axis_tdata[161];
  assign item.dgram_tag  = s_axis_tdata[177:162];
  assign item.elapsed_ms = s_axis_tdata[193:178];

  logic      busy;
  logic      start;
  out_item_t res;
  logic      res_push;
  logic      space;
  out_item_t head;

  assign s_axis_tready = !busy;
  assign start         = s_axis_tvalid && !busy;

  are_seq #(
    .CACHE_ENTRIES  (CACHE_ENTRIES),
    .PENDING_ENTRIES(PENDING_ENTRIES),
    .QUEUE_DEPTH    (QUEUE_DEPTH)
  ) u_seq (
    .clk, .rst, .start, .item, .busy,
    .own_mac, .own_ip, .cache_ttl_ms, .request_hold_ms,
    .res, .res_push, .res_space(space)
  );

  are_out_buf u_buf (
    .clk, .rst,
    .push_item (res),
    .push      (res_push),
    .space,
    .head,
    .head_valid(m_axis_tvalid),
    .pop       (m_axis_tvalid && m_axis_tready)
  );

  assign m_axis_tuser = head.kind;
  assign m_axis_tdata = {head.out_tag, head.arp_target_ip, head.dest_mac};
  assign m_axis_tlast = head.last;
endmodule

@@ rtl/are_checker.sv @@
// Port-level checker for the ARP resolution engine, bound to the top level.
// Depends on are_pkg and the arp_resolution_engine_top ports.
module are_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [1:0]  m_axis_tuser,
  input logic [95:0] m_axis_tdata,
  input logic        m_axis_tlast
);
  import are_pkg::*;

  // An accepted request with a known command leaves the engine busy in the
  // next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser != CMD_NONE) |=> !s_axis_tready)
    else $error("engine ready right after accepting a command");

  // A broadcast request always carries the all-ones destination.
  a_bcast: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == KIND_REQ) |-> (m_axis_tdata[47:0] == BcastMac))
    else $error("ARP request without broadcast destination");

  // Drops and replies are always the final result of their request.
  a_drop_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser == KIND_DROP || m_axis_tuser == KIND_REPLY))
      |-> m_axis_tlast)
    else $error("drop or reply not marked last");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) &&
      $stable(m_axis_tuser) && $stable(m_axis_tlast)))
    else $error("result changed while stalled");
endmodule

bind arp_resolution_engine_top are_checker u_chk (
  .clk, .rst, .s_axis_tvalid, .s_axis_tready, .s_axis_tuser,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tuser, .m_axis_tdata, .m_axis_tlast
);
